FILE: hdl/ssq_pkg.sv
// Shared types and constants for the sorted shift priority queue.
package ssq_pkg;

  localparam int PRIO_W = 9;
  localparam int DATA_W = 32;
  localparam int COUNT_OUT_W = 5;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 9'd256;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_POP       = 2'd1,
    OP_DEL_EQUAL = 2'd2,
    OP_DEL_BELOW = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } slot_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              at_or_below;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

FILE: hdl/ssq_if.sv
// Request and response channel interfaces.
interface ssq_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic [ssq_pkg::PRIO_W-1:0]          priority_req;
  logic signed [ssq_pkg::DATA_W-1:0]   entry_data;

  modport source (output valid, output operation, output priority_req, output entry_data,
                  input ready);
  modport sink (input valid, input operation, input priority_req, input entry_data,
                output ready);
endinterface

interface ssq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic [ssq_pkg::COUNT_OUT_W-1:0]       entry_count;
  logic                                  is_full_flag;
  logic                                  is_empty_flag;
  logic [ssq_pkg::PRIO_W-1:0]            head_priority;
  logic signed [ssq_pkg::DATA_W-1:0]     head_data;

  modport source (output valid, output status, output entry_count, output is_full_flag,
                  output is_empty_flag, output head_priority, output head_data,
                  input ready);
  modport sink (input valid, input status, input entry_count, input is_full_flag,
                input is_empty_flag, input head_priority, input head_data,
                output ready);
endinterface

FILE: hdl/sorted_shift_priority_queue.sv
// Sorted shift priority queue top level: control sequencer and the row of cells.
// A row of QUEUE_DEPTH cells holds the entries sorted by ascending priority; priority
// 0 sits in the front cell and leaves first, equal priorities keep arrival order. One
// request beat is taken at a time. For insert and pop, every cell compares and shifts by
// one place as the request beat is taken; the response register is then loaded once it
// is free. A delete moves the cells by one place per cycle, one removed entry each time,
// until a step finds that nothing is left to remove, and then loads the response
// register once it is free.
// The response register lets the next request beat enter while a response waits.
module sorted_shift_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  ssq_req_if.sink  req,
  ssq_rsp_if.source rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = ssq_pkg::PRIO_W;
  localparam int DW = ssq_pkg::DATA_W;
  localparam int OW = ssq_pkg::COUNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DELETE = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  ssq_pkg::status_t      status, status_next;
  logic [PW-1:0]         bound;
  logic                  at_or_below;
  ssq_pkg::cell_ctrl_t   ctrl;

  ssq_pkg::slot_t        slots [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keeps;
  logic [QUEUE_DEPTH-1:0] hits;
  logic                  any_match;
  logic                  accept;
  logic                  queue_empty;
  logic                  is_full;
  logic                  prio_bad;
  logic                  load_rsp;
  logic [CW+OW-1:0]      count_wide;

  logic                  rsp_valid;
  ssq_pkg::status_t      rsp_status;
  logic [OW-1:0]         rsp_count;
  logic                  rsp_full;
  logic                  rsp_empty;
  logic [PW-1:0]         rsp_prio;
  logic [DW-1:0]         rsp_data;

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign queue_empty = (count == '0);
  assign is_full     = (count == CW'(QUEUE_DEPTH));
  assign prio_bad    = (req.priority_req > ssq_pkg::PRIO_MAX);
  assign any_match   = |hits;
  assign load_rsp    = (state == S_REPORT) && (!rsp_valid || rsp.ready);
  assign count_wide  = {{OW{1'b0}}, count};

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      ssq_pkg::slot_t left_slot;
      ssq_pkg::slot_t right_slot;
      logic           left_keep;
      if (gi == 0) begin : g_front
        assign left_slot = '0;
        assign left_keep = 1'b1;
      end else begin : g_inner
        assign left_slot = slots[gi-1];
        assign left_keep = keeps[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_back
        assign right_slot = '0;
      end else begin : g_body
        assign right_slot = slots[gi+1];
      end
      ssq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .left_slot  (left_slot),
        .left_keep  (left_keep),
        .right_slot (right_slot),
        .slot       (slots[gi]),
        .keep       (keeps[gi]),
        .match      (hits[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next       = state;
    count_next       = count;
    status_next      = status;
    ctrl.cmd         = ssq_pkg::CMD_HOLD;
    ctrl.at_or_below = at_or_below;
    ctrl.prio        = bound;
    ctrl.data        = req.entry_data;
    case (state)
      S_IDLE: begin
        ctrl.prio        = req.priority_req;
        ctrl.at_or_below = (ssq_pkg::op_t'(req.operation) == ssq_pkg::OP_DEL_BELOW);
        if (accept) begin
          state_next  = S_REPORT;
          status_next = ssq_pkg::ST_DONE;
          case (ssq_pkg::op_t'(req.operation))
            ssq_pkg::OP_INSERT: begin
              if (is_full) begin
                status_next = ssq_pkg::ST_FULL;
              end else if (prio_bad) begin
                status_next = ssq_pkg::ST_RANGE;
              end else begin
                ctrl.cmd   = ssq_pkg::CMD_INSERT;
                count_next = count + CW'(1);
              end
            end
            ssq_pkg::OP_POP: begin
              if (queue_empty) begin
                status_next = ssq_pkg::ST_EMPTY;
              end else begin
                ctrl.cmd   = ssq_pkg::CMD_POP;
                count_next = count - CW'(1);
              end
            end
            default: begin
              if (queue_empty) begin
                status_next = ssq_pkg::ST_EMPTY;
              end else if (prio_bad) begin
                status_next = ssq_pkg::ST_RANGE;
              end else begin
                state_next = S_DELETE;
              end
            end
          endcase
        end
      end
      S_DELETE: begin
        if (any_match) begin
          ctrl.cmd   = ssq_pkg::CMD_DELETE;
          count_next = count - CW'(1);
        end else begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    if (accept) begin
      bound       <= req.priority_req;
      at_or_below <= (ssq_pkg::op_t'(req.operation) == ssq_pkg::OP_DEL_BELOW);
    end
    if (load_rsp) begin
      rsp_status <= status;
      rsp_count  <= count_wide[OW-1:0];
      rsp_full   <= is_full;
      rsp_empty  <= queue_empty;
      rsp_prio   <= queue_empty ? '0 : slots[0].prio;
      rsp_data   <= queue_empty ? '0 : slots[0].data;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.entry_count   = rsp_count;
  assign rsp.is_full_flag  = rsp_full;
  assign rsp.is_empty_flag = rsp_empty;
  assign rsp.head_priority = rsp_prio;
  assign rsp.head_data     = rsp_data;

endmodule

FILE: hdl/ssq_cell.sv
// One queue slot: compares against the request and shifts with its neighbors.
module ssq_cell (
  input  logic                clk,
  input  logic                rst,
  input  ssq_pkg::cell_ctrl_t ctrl,
  input  ssq_pkg::slot_t      left_slot,
  input  logic                left_keep,
  input  ssq_pkg::slot_t      right_slot,
  output ssq_pkg::slot_t      slot,
  output logic                keep,
  output logic                match
);

  logic suffix;

  assign keep   = slot.valid && (slot.prio <= ctrl.prio);
  assign match  = slot.valid &&
                  ((slot.prio == ctrl.prio) || (ctrl.at_or_below && (slot.prio < ctrl.prio)));
  assign suffix = ctrl.at_or_below || !(slot.valid && (slot.prio < ctrl.prio));

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      ssq_pkg::CMD_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            slot.prio <= ctrl.prio;
            slot.data <= ctrl.data;
          end else begin
            slot.prio <= left_slot.prio;
            slot.data <= left_slot.data;
          end
        end
      end
      ssq_pkg::CMD_POP: begin
        slot.prio <= right_slot.prio;
        slot.data <= right_slot.data;
      end
      ssq_pkg::CMD_DELETE: begin
        if (suffix) begin
          slot.prio <= right_slot.prio;
          slot.data <= right_slot.data;
        end
      end
      default: begin
      end
    endcase
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      case (ctrl.cmd)
        ssq_pkg::CMD_INSERT: begin
          if (!keep) begin
            slot.valid <= left_keep ? 1'b1 : left_slot.valid;
          end
        end
        ssq_pkg::CMD_POP: begin
          slot.valid <= right_slot.valid;
        end
        ssq_pkg::CMD_DELETE: begin
          if (suffix) begin
            slot.valid <= right_slot.valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_sorted_shift_priority_queue.sv
// Self-checking testbench for the sorted shift priority queue: directed table, then random ops.
module tb_sorted_shift_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_OPS = 500;
  localparam int IDLE_PCT = 38;

  typedef struct packed {
    ssq_pkg::status_t                status;
    logic [ssq_pkg::COUNT_OUT_W-1:0] count;
    logic                            full;
    logic                            empty;
    logic [ssq_pkg::PRIO_W-1:0]      head_prio;
    logic [ssq_pkg::DATA_W-1:0]      head_data;
  } queue_view_t;

  typedef struct packed {
    ssq_pkg::op_t               op;
    logic [ssq_pkg::PRIO_W-1:0] prio;
    logic [ssq_pkg::DATA_W-1:0] data;
    logic [4:0]                 reps;
    logic                       rand_prio;
    logic                       typed;
    queue_view_t                want;
  } stim_row_t;

  localparam queue_view_t EMPTY_DONE =
    '{ssq_pkg::ST_DONE, 5'd0, 1'b0, 1'b1, 9'd0, 32'd0};
  localparam queue_view_t EMPTY_FAIL =
    '{ssq_pkg::ST_EMPTY, 5'd0, 1'b0, 1'b1, 9'd0, 32'd0};

  localparam int NUM_ROWS = 17;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ssq_pkg::OP_POP,       9'd0,   32'd0,         5'd1,  1'b0, 1'b1, EMPTY_FAIL},
    '{ssq_pkg::OP_DEL_EQUAL, 9'd5,   32'd0,         5'd1,  1'b0, 1'b1, EMPTY_FAIL},
    '{ssq_pkg::OP_DEL_BELOW, 9'd300, 32'd0,         5'd1,  1'b0, 1'b1, EMPTY_FAIL},
    '{ssq_pkg::OP_INSERT,    9'd511, 32'h1234_5678, 5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_RANGE, 5'd0, 1'b0, 1'b1, 9'd0, 32'd0}},
    '{ssq_pkg::OP_INSERT,    9'd256, 32'h7FFF_FFFF, 5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_DONE, 5'd1, 1'b0, 1'b0, 9'd256, 32'h7FFF_FFFF}},
    '{ssq_pkg::OP_INSERT,    9'd0,   32'h8000_0000, 5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_DONE, 5'd2, 1'b0, 1'b0, 9'd0, 32'h8000_0000}},
    '{ssq_pkg::OP_INSERT,    9'd0,   32'hFFFF_FFFF, 5'd1,  1'b0, 1'b0, '0},
    '{ssq_pkg::OP_INSERT,    9'd0,   32'd0,         5'd13, 1'b1, 1'b0, '0},
    '{ssq_pkg::OP_INSERT,    9'd300, 32'd0,         5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_FULL, 5'd16, 1'b1, 1'b0, 9'd0, 32'h8000_0000}},
    '{ssq_pkg::OP_DEL_EQUAL, 9'd300, 32'd0,         5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_RANGE, 5'd16, 1'b1, 1'b0, 9'd0, 32'h8000_0000}},
    '{ssq_pkg::OP_POP,       9'd511, 32'd0,         5'd1,  1'b0, 1'b0, '0},
    '{ssq_pkg::OP_DEL_BELOW, 9'd256, 32'd0,         5'd1,  1'b0, 1'b1, EMPTY_DONE},
    '{ssq_pkg::OP_INSERT,    9'd5,   32'd5,         5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_DONE, 5'd1, 1'b0, 1'b0, 9'd5, 32'd5}},
    '{ssq_pkg::OP_DEL_EQUAL, 9'd6,   32'd0,         5'd1,  1'b0, 1'b1,
      '{ssq_pkg::ST_DONE, 5'd1, 1'b0, 1'b0, 9'd5, 32'd5}},
    '{ssq_pkg::OP_INSERT,    9'd200, 32'hA5A5_A5A5, 5'd1,  1'b0, 1'b0, '0},
    '{ssq_pkg::OP_DEL_EQUAL, 9'd5,   32'd0,         5'd1,  1'b0, 1'b0, '0},
    '{ssq_pkg::OP_POP,       9'd0,   32'd0,         5'd1,  1'b0, 1'b1, EMPTY_DONE}
  };

  logic clk;
  logic rst;
  logic quiet;
  int   mismatches;

  logic [ssq_pkg::PRIO_W-1:0] mirror_prio [QUEUE_DEPTH];
  logic [ssq_pkg::DATA_W-1:0] mirror_data [QUEUE_DEPTH];
  int                         mirror_count;
  queue_view_t                pending_views [$];

  ssq_req_if req_bus ();
  ssq_rsp_if rsp_bus ();

  sorted_shift_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic queue_view_t mirror_apply(ssq_pkg::op_t op,
                                               logic [ssq_pkg::PRIO_W-1:0] prio,
                                               logic [ssq_pkg::DATA_W-1:0] data);
    queue_view_t v;
    int          pos;
    int          kept;
    logic        drop;
    v = '0;
    v.status = ssq_pkg::ST_DONE;
    case (op)
      ssq_pkg::OP_INSERT: begin
        if (mirror_count >= QUEUE_DEPTH) begin
          v.status = ssq_pkg::ST_FULL;
        end else if (prio > ssq_pkg::PRIO_MAX) begin
          v.status = ssq_pkg::ST_RANGE;
        end else begin
          pos = 0;
          while (pos < mirror_count && mirror_prio[pos] <= prio) pos++;
          for (int i = mirror_count; i > pos; i--) begin
            mirror_prio[i] = mirror_prio[i-1];
            mirror_data[i] = mirror_data[i-1];
          end
          mirror_prio[pos] = prio;
          mirror_data[pos] = data;
          mirror_count++;
        end
      end
      ssq_pkg::OP_POP: begin
        if (mirror_count == 0) begin
          v.status = ssq_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < mirror_count; i++) begin
            mirror_prio[i] = mirror_prio[i+1];
            mirror_data[i] = mirror_data[i+1];
          end
          mirror_count--;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          v.status = ssq_pkg::ST_EMPTY;
        end else if (prio > ssq_pkg::PRIO_MAX) begin
          v.status = ssq_pkg::ST_RANGE;
        end else begin
          kept = 0;
          for (int i = 0; i < mirror_count; i++) begin
            drop = (mirror_prio[i] == prio) ||
                   (op == ssq_pkg::OP_DEL_BELOW && mirror_prio[i] < prio);
            if (!drop) begin
              mirror_prio[kept] = mirror_prio[i];
              mirror_data[kept] = mirror_data[i];
              kept++;
            end
          end
          mirror_count = kept;
        end
      end
    endcase
    v.count = mirror_count[ssq_pkg::COUNT_OUT_W-1:0];
    v.full = (mirror_count == QUEUE_DEPTH);
    v.empty = (mirror_count == 0);
    v.head_prio = (mirror_count != 0) ? mirror_prio[0] : '0;
    v.head_data = (mirror_count != 0) ? mirror_data[0] : '0;
    return v;
  endfunction

  function automatic logic [ssq_pkg::PRIO_W-1:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return ssq_pkg::PRIO_W'($urandom_range(0, 15));
    if (sel < 85) return ssq_pkg::PRIO_W'($urandom_range(0, 256));
    if (sel < 90) return ssq_pkg::PRIO_MAX;
    return ssq_pkg::PRIO_W'($urandom_range(257, 511));
  endfunction

  task automatic send_beat(ssq_pkg::op_t op, logic [ssq_pkg::PRIO_W-1:0] prio,
                           logic [ssq_pkg::DATA_W-1:0] data,
                           logic typed, queue_view_t typed_view);
    queue_view_t view;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.operation <= op;
    req_bus.priority_req <= prio;
    req_bus.entry_data <= data;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    view = mirror_apply(op, prio, data);
    pending_views.push_back(typed ? typed_view : view);
  endtask

  task automatic check_view(queue_view_t want);
    if (rsp_bus.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
      mismatches++;
    end
    if (rsp_bus.entry_count !== want.count) begin
      $error("entry_count: expected %0d, got %0d", want.count, rsp_bus.entry_count);
      mismatches++;
    end
    if (rsp_bus.is_full_flag !== want.full) begin
      $error("is_full_flag: expected %0b, got %0b", want.full, rsp_bus.is_full_flag);
      mismatches++;
    end
    if (rsp_bus.is_empty_flag !== want.empty) begin
      $error("is_empty_flag: expected %0b, got %0b", want.empty, rsp_bus.is_empty_flag);
      mismatches++;
    end
    if (rsp_bus.head_priority !== want.head_prio) begin
      $error("head_priority: expected %0d, got %0d", want.head_prio, rsp_bus.head_priority);
      mismatches++;
    end
    if (rsp_bus.head_data !== want.head_data) begin
      $error("head_data: expected %h, got %h", want.head_data, rsp_bus.head_data);
      mismatches++;
    end
  endtask

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_views.size() == 0) begin
        $error("response beat with no request outstanding");
        mismatches++;
      end else begin
        check_view(pending_views[0]);
        pending_views.delete(0);
      end
    end
  end

  initial begin
    int unsigned                fill_bias;
    int unsigned                roll;
    ssq_pkg::op_t               op;
    logic [ssq_pkg::PRIO_W-1:0] prio;
    logic [ssq_pkg::DATA_W-1:0] data;
    rst = 1'b1;
    quiet = 1'b0;
    mismatches = 0;
    mirror_count = 0;
    fill_bias = 50;
    req_bus.valid = 1'b0;
    req_bus.operation = ssq_pkg::OP_INSERT;
    req_bus.priority_req = '0;
    req_bus.entry_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      for (int k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
        prio = DIRECTED_ROWS[r].rand_prio ? ssq_pkg::PRIO_W'($urandom_range(0, 256))
                                          : DIRECTED_ROWS[r].prio;
        data = DIRECTED_ROWS[r].rand_prio ? ssq_pkg::DATA_W'($urandom)
                                          : DIRECTED_ROWS[r].data;
        send_beat(DIRECTED_ROWS[r].op, prio, data, DIRECTED_ROWS[r].typed,
                  DIRECTED_ROWS[r].want);
      end
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) fill_bias = $urandom_range(25, 75);
      quiet = (n >= 200 && n < 300);
      roll = $urandom_range(0, 99);
      if (roll < fill_bias) begin
        op = ssq_pkg::OP_INSERT;
      end else begin
        roll = $urandom_range(0, 99);
        op = (roll < 55) ? ssq_pkg::OP_POP :
             (roll < 80) ? ssq_pkg::OP_DEL_EQUAL : ssq_pkg::OP_DEL_BELOW;
      end
      prio = pick_priority();
      if (op == ssq_pkg::OP_DEL_BELOW && prio <= ssq_pkg::PRIO_MAX &&
          $urandom_range(0, 1) == 0)
        prio = ssq_pkg::PRIO_W'($urandom_range(0, 8));
      data = ssq_pkg::DATA_W'($urandom);
      send_beat(op, prio, data, 1'b0, '0);
    end
    quiet = 1'b0;
    req_bus.valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ssq_pkg.sv
hdl/ssq_if.sv
hdl/ssq_cell.sv
hdl/sorted_shift_priority_queue.sv
tb/tb_sorted_shift_priority_queue.sv
